>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> hdl/ffdc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffdc_pkg
// Types, constants and the CRC16-Modbus bit step for the frame deframer.
// ---------------------------------------------------------------------------
package ffdc_pkg;

  localparam int          HDR_BYTES  = 4;   // marker, marker, command, length
  localparam int          LEN_W      = 5;   // payload_length / byte_index width
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [2:0]  CRC_STEPS_LEFT = 3'd7;  // bit steps after the first

  // configuration register indexes
  localparam logic REG_START_FIRST  = 1'b0;
  localparam logic REG_START_SECOND = 1'b1;

  localparam logic STATUS_GOOD    = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT_FIRST,
    PH_HUNT_SECOND,
    PH_COLLECT
  } hunt_phase_t;

  typedef enum logic [1:0] {
    SQ_RUN,
    SQ_READ,
    SQ_LOAD
  } seq_state_t;

  typedef struct packed {
    logic init;   // restart at CRC_INIT
    logic feed;   // start a byte
  } crc_ctrl_t;

  function automatic logic [15:0] crc_bit_step(input logic [15:0] c);
    crc_bit_step = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction

endpackage

>>> hdl/ffdc_crc16.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffdc_crc16
// Bit-serial CRC16-Modbus engine: a byte is folded in one bit step at a time.
// ---------------------------------------------------------------------------
module ffdc_crc16 (
  input  logic                clk,
  input  logic                rst,
  input  ffdc_pkg::crc_ctrl_t ctrl,
  input  logic [7:0]          data_byte,
  output logic [15:0]         crc,
  output logic                busy
);
  import ffdc_pkg::*;

  logic [2:0] steps_left;

  // first bit step is taken in the feed cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= CRC_INIT;
      steps_left <= '0;
    end else if (ctrl.init) begin
      crc        <= CRC_INIT;
      steps_left <= '0;
    end else if (ctrl.feed) begin
      crc        <= crc_bit_step(crc ^ {8'h00, data_byte});
      steps_left <= CRC_STEPS_LEFT;
    end else if (steps_left != 3'd0) begin
      crc        <= crc_bit_step(crc);
      steps_left <= steps_left - 3'd1;
    end
  end

  assign busy = (steps_left != 3'd0);

endmodule

>>> hdl/fixed_frame_deframer_crc16_unit.sv
`timescale 1ns / 1ps
// Input: a command, length or data byte holds the input through its accept and the
//   CRC bit steps in the bit-serial CRC engine; marker, noise and CRC bytes take no CRC bit steps.
// Results: a CRC error or zero-length item is valid in the cycle after the final
//   byte; a good frame's items follow it one at a time, each by a payload memory
//   read, then an output register load that waits until the output is free.
// Reset: rst is synchronous, active high; control and CRC state clear, the
//   payload memory is not cleared (every entry read is written first).
// ---------------------------------------------------------------------------
// fixed_frame_deframer_crc16_unit
// Fixed-length frame deframer: marker hunt, CRC16-Modbus check, payload out.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_frame_deframer_crc16_unit #(
  parameter int DATA_BYTES  = 24,
  parameter int FRAME_BYTES = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [7:0]                cfg_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                rx_byte,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      frame_status,
  output logic [7:0]                command,
  output logic [ffdc_pkg::LEN_W-1:0] payload_length,
  output logic [7:0]                payload_byte,
  output logic [ffdc_pkg::LEN_W-1:0] byte_index,
  output logic                      last_of_frame
);
  import ffdc_pkg::*;

  // data field actually used when the parameters disagree
  localparam int EFF_DATA = (DATA_BYTES < FRAME_BYTES - 6) ? DATA_BYTES : FRAME_BYTES - 6;
  localparam int PW       = $clog2(FRAME_BYTES);
  localparam int AW       = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

  localparam logic [PW-1:0]    POS_CMD    = PW'(2);
  localparam logic [PW-1:0]    POS_LEN    = PW'(3);
  localparam logic [PW-1:0]    POS_DATA   = PW'(HDR_BYTES);
  localparam logic [PW-1:0]    POS_CRC_LO = PW'(FRAME_BYTES - 2);
  localparam logic [PW-1:0]    POS_LAST   = PW'(FRAME_BYTES - 1);
  localparam logic [PW-1:0]    DATA_CNT   = PW'(EFF_DATA);
  localparam logic [LEN_W-1:0] EFF_LEN    = LEN_W'(EFF_DATA);

  // ---- configuration registers ----
  logic [7:0] start_first;
  logic [7:0] start_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_first  <= 8'hAA;
      start_second <= 8'h55;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_FIRST:  start_first  <= cfg_data;
        REG_START_SECOND: start_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- frame state ----
  hunt_phase_t      phase, phase_next;
  logic [PW-1:0]    pos, pos_next;
  logic [7:0]       held_cmd, held_cmd_next;
  logic [7:0]       held_len, held_len_next;
  logic [7:0]       crc_lo, crc_lo_next;

  seq_state_t       seq, seq_next;
  logic [LEN_W-1:0] emit_idx;
  logic [LEN_W-1:0] len_hold;

  crc_ctrl_t        crc_ctrl;
  logic [15:0]      crc;
  logic             crc_busy;

  logic             in_accept;
  logic             out_take;
  logic             final_byte;   // accepted byte is the CRC high byte
  logic             crc_match;
  logic [LEN_W-1:0] len_clamped;
  logic             direct_load;  // error or zero-length item straight to output
  logic             mem_load;     // payload item from the store
  logic             rd_en;
  logic             emit_last;

  // payload store: one write port from the collector, one read port for output
  logic [7:0]       store [DATA_BYTES];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       rd_data;
  logic [PW-1:0]    data_off;

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // bytes stall during CRC bit steps, during payload readout, and the final
  // byte waits until the output register is free
  assign in_stall = (seq != SQ_RUN) || crc_busy ||
                    (out_valid && (phase == PH_COLLECT) && (pos == POS_LAST));

  assign len_clamped = (held_len < 8'(EFF_DATA)) ? LEN_W'(held_len) : EFF_LEN;
  assign crc_match   = ({rx_byte, crc_lo} == crc);
  assign final_byte  = in_accept && (phase == PH_COLLECT) && (pos == POS_LAST);
  assign data_off    = pos - POS_DATA;

  // byte-level hunt / collect
  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    held_cmd_next = held_cmd;
    held_len_next = held_len;
    crc_lo_next   = crc_lo;
    crc_ctrl      = '0;
    mem_we        = 1'b0;
    mem_waddr     = AW'(data_off);
    if (in_accept) begin
      case (phase)
        PH_HUNT_FIRST: begin
          if (rx_byte == start_first) phase_next = PH_HUNT_SECOND;
        end
        PH_HUNT_SECOND: begin
          // second marker wins when both markers are equal
          if (rx_byte == start_second) begin
            phase_next    = PH_COLLECT;
            pos_next      = POS_CMD;
            crc_ctrl.init = 1'b1;
          end else if (rx_byte != start_first) begin
            phase_next = PH_HUNT_FIRST;
          end
        end
        PH_COLLECT: begin
          if (pos < POS_CRC_LO) begin
            crc_ctrl.feed = 1'b1;
            if (pos == POS_CMD) held_cmd_next = rx_byte;
            else if (pos == POS_LEN) held_len_next = rx_byte;
            else if ((pos >= POS_DATA) && (data_off < DATA_CNT)) mem_we = 1'b1;
            pos_next = pos + PW'(1);
          end else if (pos == POS_CRC_LO) begin
            crc_lo_next = rx_byte;
            pos_next    = pos + PW'(1);
          end else begin
            phase_next    = PH_HUNT_FIRST;
            pos_next      = '0;
            crc_ctrl.init = 1'b1;
          end
        end
        default: phase_next = PH_HUNT_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT_FIRST;
      pos      <= '0;
      held_cmd <= '0;
      held_len <= '0;
      crc_lo   <= '0;
    end else begin
      phase    <= phase_next;
      pos      <= pos_next;
      held_cmd <= held_cmd_next;
      held_len <= held_len_next;
      crc_lo   <= crc_lo_next;
    end
  end

  ffdc_crc16 u_crc (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (crc_ctrl),
    .data_byte (rx_byte),
    .crc       (crc),
    .busy      (crc_busy)
  );

  // ---- payload readout sequencer ----
  assign emit_last = ((emit_idx + LEN_W'(1)) == len_hold);

  always_comb begin
    seq_next = seq;
    case (seq)
      SQ_RUN: begin
        if (final_byte && crc_match && (len_clamped != '0)) seq_next = SQ_READ;
      end
      SQ_READ: seq_next = SQ_LOAD;
      SQ_LOAD: begin
        if (!out_valid) seq_next = emit_last ? SQ_RUN : SQ_READ;
      end
      default: seq_next = SQ_RUN;
    endcase
  end

  always_comb begin
    rd_en       = 1'b0;
    mem_load    = 1'b0;
    direct_load = 1'b0;
    case (seq)
      SQ_RUN:  direct_load = final_byte && (!crc_match || (len_clamped == '0));
      SQ_READ: rd_en = 1'b1;
      SQ_LOAD: mem_load = !out_valid;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq      <= SQ_RUN;
      emit_idx <= '0;
      len_hold <= '0;
    end else begin
      seq <= seq_next;
      if (final_byte) begin
        emit_idx <= '0;
        len_hold <= len_clamped;
      end else if (mem_load) begin
        emit_idx <= emit_idx + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= rx_byte;
    if (rd_en)  rd_data <= store[AW'(emit_idx)];
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (direct_load || mem_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (direct_load) begin
      frame_status   <= crc_match ? STATUS_GOOD : STATUS_CRC_ERR;
      command        <= held_cmd;
      payload_length <= len_clamped;
      payload_byte   <= 8'h00;
      byte_index     <= '0;
      last_of_frame  <= 1'b1;
    end else if (mem_load) begin
      frame_status   <= STATUS_GOOD;
      command        <= held_cmd;
      payload_length <= len_hold;
      payload_byte   <= rd_data;
      byte_index     <= emit_idx;
      last_of_frame  <= emit_last;
    end
  end

  // ---- checks ----
  // CRC engine only steps while a frame is being collected
  `ASSERT_HOLDS(a_crc_busy_collect, clk, rst, !crc_busy || (phase == PH_COLLECT))
  // a result is never written over one still waiting
  `ASSERT_HOLDS(a_no_overwrite, clk, rst, !(out_valid && (direct_load || mem_load)))
  // readout never runs past the clamped length
  `ASSERT_HOLDS(a_idx_bound, clk, rst, (seq == SQ_RUN) || (emit_idx < len_hold))
  // a payload load is shown in the next cycle
  `ASSERT_NEXT(a_load_shows, clk, rst, mem_load, out_valid && (byte_index == $past(emit_idx)))

endmodule
